>>> hw/rtl/assert_macros.svh
// assertion helpers, disabled in synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define TRE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define TRE_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`else

`define TRE_ASSERT(lbl, prop, msg)

`define TRE_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

>>> hw/rtl/tre_pkg.sv
`default_nettype none

package tre_pkg;

	localparam int MAX_ORDER = 64;
	localparam int SUM_WIDTH = 40;
	localparam int LINE_W    = $clog2(MAX_ORDER);
	localparam int ORDER_W   = 7;
	localparam int CNT_W     = $clog2(MAX_ORDER + 1);
	localparam int MAG_W     = 32;
	localparam int NUM_W     = MAG_W + 16;
	localparam int DCNT_W    = $clog2(NUM_W + 1);
	localparam int Q_W       = 17;

	localparam logic [NUM_W-1:0] UNIT_NUM = NUM_W'(64'h1_0000_0000);
	localparam logic [Q_W-1:0]   Q_ONE    = Q_W'(65536);

	localparam logic [1:0] CFG_NORM_MODE = 2'd0;
	localparam logic [1:0] CFG_UPPER     = 2'd1;
	localparam logic [1:0] CFG_UNIT_DIAG = 2'd2;
	localparam logic [1:0] CFG_ORDER     = 2'd3;

	localparam logic [1:0] MODE_ONE_NORM = 2'd0;
	localparam logic [1:0] MODE_INF_NORM = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_SCAN,
		ST_PREP,
		ST_DIV,
		ST_PUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic scan_init;
		logic scan_step;
		logic prep;
		logic div_step;
		logic load_out;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic div_done;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

>>> hw/rtl/triangular_rcond_estimate.sv
`default_nettype none
`include "assert_macros.svh"

// Reciprocal condition estimate of a triangular matrix. Elements stream in one
// per cycle while in_stall is low (Q16.16, tagged with row and column); each
// goes through a read-modify-write of the 64-entry sum store (registered read,
// then add and write back), with forwarding between back to back elements to
// the same entry. After the transaction carrying last_element the input stalls
// while the block drains the pipeline, scans the sum store for the largest sum
// one entry per cycle, sets up the divide and runs a restoring divider that
// produces one quotient bit per cycle, then loads the result register once the
// previous result is no longer stalled. The sum store is cleared by per-entry
// valid bits, so no clearing pass is needed after reset or between matrices.
module triangular_rcond_estimate (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [1:0]                  cfg_index,
	input  logic [tre_pkg::ORDER_W-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [31:0]          element_value,
	input  logic [5:0]                  row_index,
	input  logic [5:0]                  col_index,
	input  logic                        last_element,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [tre_pkg::Q_W-1:0]     recip_cond,
	output logic                        singular_flag
);

	tre_pkg::cmd_t    cmd;
	tre_pkg::status_t status;

	tre_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.last_element (last_element),
		.status       (status),
		.cmd          (cmd),
		.in_stall     (in_stall)
	);

	tre_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.element_value (element_value),
		.row_index     (row_index),
		.col_index     (col_index),
		.recip_cond    (recip_cond),
		.singular_flag (singular_flag),
		.out_valid     (out_valid),
		.out_stall     (out_stall)
	);

	`TRE_ASSERT(a_sing_zero, (out_valid && singular_flag) |-> (recip_cond == '0), "singular result not zero")
	`TRE_ASSERT(a_clamp, out_valid |-> (recip_cond <= tre_pkg::Q_ONE), "result above one")
	`TRE_ASSERT_NEXT(a_last_stalls, in_valid && !in_stall && last_element, in_stall, "input open after last element")
	`TRE_ASSERT(a_load_idle, cmd.load_out |-> !cmd.accept, "result load during element transaction")

endmodule

`default_nettype wire

>>> hw/rtl/tre_ctrl.sv
`default_nettype none

module tre_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             last_element,
	input  tre_pkg::status_t status,
	output tre_pkg::cmd_t    cmd,
	output logic             in_stall
);

	tre_pkg::state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tre_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			tre_pkg::ST_IDLE: begin
				if (in_valid && last_element) state_next = tre_pkg::ST_DRAIN;
			end
			tre_pkg::ST_DRAIN: state_next = tre_pkg::ST_SCAN;
			tre_pkg::ST_SCAN: begin
				if (status.scan_done) state_next = tre_pkg::ST_PREP;
			end
			tre_pkg::ST_PREP: state_next = tre_pkg::ST_DIV;
			tre_pkg::ST_DIV: begin
				if (status.div_done) state_next = tre_pkg::ST_PUT;
			end
			tre_pkg::ST_PUT: begin
				if (status.out_free) state_next = tre_pkg::ST_IDLE;
			end
			default: state_next = tre_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			tre_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.accept = in_valid;
			end
			tre_pkg::ST_DRAIN: cmd.scan_init = 1'b1;
			tre_pkg::ST_SCAN: cmd.scan_step = 1'b1;
			tre_pkg::ST_PREP: cmd.prep = 1'b1;
			tre_pkg::ST_DIV: cmd.div_step = !status.div_done;
			tre_pkg::ST_PUT: begin
				cmd.load_out = status.out_free;
				cmd.clear = status.out_free;
			end
			default: in_stall = 1'b1;
		endcase
	end

endmodule

`default_nettype wire

>>> hw/rtl/tre_dpath.sv
`default_nettype none

module tre_dpath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tre_pkg::cmd_t                cmd,
	output tre_pkg::status_t             status,
	input  logic                         cfg_write,
	input  logic [1:0]                   cfg_index,
	input  logic [tre_pkg::ORDER_W-1:0]  cfg_data,
	input  logic signed [31:0]           element_value,
	input  logic [5:0]                   row_index,
	input  logic [5:0]                   col_index,
	output logic [tre_pkg::Q_W-1:0]      recip_cond,
	output logic                         singular_flag,
	output logic                         out_valid,
	input  logic                         out_stall
);

	localparam int SW = tre_pkg::SUM_WIDTH;
	localparam int LW = tre_pkg::LINE_W;
	localparam int MW = tre_pkg::MAG_W;
	localparam int NW = tre_pkg::NUM_W;
	localparam int QW = tre_pkg::Q_W;

	logic [1:0]                  norm_mode_q;
	logic                        upper_q;
	logic                        unit_diag_q;
	logic [tre_pkg::ORDER_W-1:0] order_q;
	logic [tre_pkg::ORDER_W-1:0] n_eff;

	logic [SW-1:0] sum_mem [tre_pkg::MAX_ORDER];
	logic [SW-1:0] rd_data_q;
	logic [LW-1:0] rd_addr;
	logic [tre_pkg::MAX_ORDER-1:0] vld_q;

	logic [MW-1:0] raw, mag;
	logic          in_range, in_tri, use_elem, add_in;
	logic [LW-1:0] line_in;

	logic          add_s1;
	logic [LW-1:0] line_s1;
	logic [MW-1:0] mag_s1;
	logic          fwd_q;
	logic [SW-1:0] fwd_data_q;
	logic [SW-1:0] base_sum;
	logic [SW:0]   wide_sum;
	logic [SW-1:0] new_sum;

	logic [MW-1:0] min_q;

	logic [tre_pkg::CNT_W-1:0] cnt_q;
	logic          sv_s1, sval_s1;
	logic [SW-1:0] max_q;

	logic [SW-1:0] norm_q;
	logic          sing_q;
	logic [NW-1:0] num_q;
	logic [SW-1:0] rem_q;
	logic [tre_pkg::DCNT_W-1:0] dcnt_q;
	logic [QW-1:0] q_q;
	logic          over_q;
	logic [SW:0]   trial, diff;
	logic          ge;

	assign n_eff = (order_q > tre_pkg::ORDER_W'(tre_pkg::MAX_ORDER)) ?
		tre_pkg::ORDER_W'(tre_pkg::MAX_ORDER) : order_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_mode_q <= tre_pkg::MODE_ONE_NORM;
			upper_q <= 1'b1;
			unit_diag_q <= 1'b0;
			order_q <= tre_pkg::ORDER_W'(64);
		end else if (cfg_write) begin
			case (cfg_index)
				tre_pkg::CFG_NORM_MODE: norm_mode_q <= cfg_data[1:0];
				tre_pkg::CFG_UPPER: upper_q <= cfg_data[0];
				tre_pkg::CFG_UNIT_DIAG: unit_diag_q <= cfg_data[0];
				tre_pkg::CFG_ORDER: order_q <= cfg_data;
				default: order_q <= order_q;
			endcase
		end
	end

	// element decode
	assign raw = element_value;
	assign mag = raw[MW-1] ? MW'(0 - raw) : raw;
	assign in_range = ({1'b0, row_index} < n_eff) && ({1'b0, col_index} < n_eff);
	assign in_tri = upper_q ? (row_index <= col_index) : (row_index >= col_index);
	assign use_elem = cmd.accept && in_range && in_tri;
	assign add_in = use_elem && (norm_mode_q == tre_pkg::MODE_ONE_NORM ||
		norm_mode_q == tre_pkg::MODE_INF_NORM);
	assign line_in = (norm_mode_q == tre_pkg::MODE_ONE_NORM) ? col_index : row_index;
	assign rd_addr = cmd.scan_step ? cnt_q[LW-1:0] : line_in;

	// saturating accumulate
	assign base_sum = fwd_q ? fwd_data_q : (vld_q[line_s1] ? rd_data_q : '0);
	assign wide_sum = {1'b0, base_sum} + (SW + 1)'(mag_s1);
	assign new_sum = wide_sum[SW] ? '1 : wide_sum[SW-1:0];

	always_ff @(posedge clk) begin
		if (add_s1) sum_mem[line_s1] <= new_sum;
		rd_data_q <= sum_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			add_s1 <= 1'b0;
			fwd_q <= 1'b0;
			min_q <= '1;
		end else begin
			add_s1 <= add_in;
			fwd_q <= add_in && add_s1 && (line_in == line_s1);
			if (cmd.clear) begin
				vld_q <= '0;
				min_q <= '1;
			end else begin
				if (add_s1) vld_q[line_s1] <= 1'b1;
				if (use_elem && row_index == col_index && mag < min_q) min_q <= mag;
			end
		end
	end

	always_ff @(posedge clk) begin
		line_s1 <= line_in;
		mag_s1 <= mag;
		fwd_data_q <= new_sum;
	end

	// max scan
	assign status.scan_done = (cnt_q >= n_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sv_s1 <= 1'b0;
		end else begin
			sv_s1 <= cmd.scan_step && !status.scan_done;
			if (cmd.scan_init) cnt_q <= '0;
			else if (cmd.scan_step && !status.scan_done) cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		sval_s1 <= vld_q[cnt_q[LW-1:0]];
		if (cmd.scan_init) max_q <= '0;
		else if (sv_s1 && sval_s1 && rd_data_q > max_q) max_q <= rd_data_q;
	end

	// restoring divide, one quotient bit per cycle
	assign trial = {rem_q, num_q[NW-1]};
	assign ge = trial >= {1'b0, norm_q};
	assign diff = trial - {1'b0, norm_q};
	assign status.div_done = (dcnt_q == tre_pkg::DCNT_W'(NW));

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			norm_q <= (norm_mode_q == tre_pkg::MODE_ONE_NORM ||
				norm_mode_q == tre_pkg::MODE_INF_NORM) ? max_q : '0;
			num_q <= unit_diag_q ? tre_pkg::UNIT_NUM : {min_q, 16'b0};
			rem_q <= '0;
			dcnt_q <= '0;
			q_q <= '0;
			over_q <= 1'b0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[SW-1:0] : trial[SW-1:0];
			num_q <= {num_q[NW-2:0], 1'b0};
			q_q <= {q_q[QW-2:0], ge};
			over_q <= over_q | q_q[QW-1];
			dcnt_q <= dcnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_step && dcnt_q == '0) begin
			sing_q <= (norm_q == '0) || (!unit_diag_q && num_q == '0);
		end
	end

	// result register
	assign status.out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			singular_flag <= sing_q;
			if (sing_q) recip_cond <= '0;
			else if (over_q || q_q > tre_pkg::Q_ONE) recip_cond <= tre_pkg::Q_ONE;
			else recip_cond <= q_q;
		end
	end

endmodule

`default_nettype wire
